>>> src/mpm_pkg.sv
// Shared constants, types and helpers for the min-peak-memory scheduler.
`default_nettype none
package mpm_pkg;

    localparam int MAX_NODES   = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int SET_W       = MAX_NODES;
    localparam int STORE_DEPTH = 1 << MAX_NODES;
    localparam int CNT_W       = 5;
    localparam int SUM_W       = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [SET_W-1:0] pred;
        logic [SET_W-1:0] succ;
        logic [SUM_W-1:0] weight;
    } node_info_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] peak;
        logic [SUM_W-1:0] live;
    } store_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] peak;
        logic             no_order;
    } result_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/mpm_ifs.sv
// Valid/ready channel interfaces for command words and result words.
`default_nettype none
interface mpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] from_node;
    logic [3:0] to_node;
    logic [15:0] edge_weight;

    modport source (output valid, command, from_node, to_node, edge_weight, input ready);
    modport sink   (input valid, command, from_node, to_node, edge_weight, output ready);
endinterface

interface mpm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] peak_memory;
    logic        no_order;

    modport source (output valid, peak_memory, no_order, input ready);
    modport sink   (input valid, peak_memory, no_order, output ready);
endinterface
`default_nettype wire

>>> src/mpm_graph.sv
// Per-node edge store: predecessor mask, successor mask, output weight total.
`default_nettype none
module mpm_graph
    import mpm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              add_en,
    input  wire logic              clr_en,
    input  wire logic [3:0]        from_node,
    input  wire logic [3:0]        to_node,
    input  wire logic [15:0]       edge_weight,
    input  wire logic [NODE_W-1:0] rd_idx,
    output node_info_t             info
);

    logic [SET_W-1:0] pred_reg [MAX_NODES];
    logic [SET_W-1:0] succ_reg [MAX_NODES];
    logic [SUM_W-1:0] wsum_reg [MAX_NODES];
    logic             in_range;

    assign in_range = (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_NODES; k++)
            begin
                pred_reg[k] <= '0;
                succ_reg[k] <= '0;
                wsum_reg[k] <= '0;
            end
        end
        else if (clr_en)
        begin
            for (int k = 0; k < MAX_NODES; k++)
            begin
                pred_reg[k] <= '0;
                succ_reg[k] <= '0;
                wsum_reg[k] <= '0;
            end
        end
        else if (add_en && in_range)
        begin
            pred_reg[to_node[NODE_W-1:0]][from_node[NODE_W-1:0]] <= 1'b1;
            succ_reg[from_node[NODE_W-1:0]][to_node[NODE_W-1:0]] <= 1'b1;
            wsum_reg[from_node[NODE_W-1:0]] <=
                sat_add(wsum_reg[from_node[NODE_W-1:0]], SUM_W'(edge_weight));
        end
    end

    assign info.pred   = pred_reg[rd_idx];
    assign info.succ   = succ_reg[rd_idx];
    assign info.weight = wsum_reg[rd_idx];

endmodule
`default_nettype wire

>>> src/mpm_dp.sv
// Subset DP sequencer around the per-set live/peak memory.
`default_nettype none
module mpm_dp
    import mpm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  node_count,
    input  wire node_info_t        info,
    output logic [NODE_W-1:0]      gidx,
    output logic                   busy,
    output logic                   res_valid,
    output result_t                res,
    input  wire logic              res_ack
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_INIT  = 4'd2;
    localparam logic [3:0] ST_SREAD = 4'd3;
    localparam logic [3:0] ST_SWAIT = 4'd4;
    localparam logic [3:0] ST_ISCAN = 4'd5;
    localparam logic [3:0] ST_NWAIT = 4'd6;
    localparam logic [3:0] ST_FREE  = 4'd7;
    localparam logic [3:0] ST_FREAD = 4'd8;
    localparam logic [3:0] ST_FWAIT = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [SET_W:0]   s_reg, s_next;
    logic [SET_W:0]   lim_reg, lim_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [NODE_W:0]  i_reg, i_next;
    logic [NODE_W:0]  v_reg, v_next;
    logic [SET_W-1:0] ns_reg, ns_next;
    logic [SET_W-1:0] pred_i_reg, pred_i_next;
    logic [SUM_W-1:0] np_reg, np_next;
    logic [SUM_W-1:0] nl_reg, nl_next;
    logic [SUM_W-1:0] speak_reg, speak_next;
    logic [SUM_W-1:0] slive_reg, slive_next;
    result_t          res_reg, res_next;

    store_word_t      mem [STORE_DEPTH];
    store_word_t      rd_q;
    store_word_t      wd;
    logic             we;
    logic [SET_W-1:0] wa, ra;

    logic [SET_W-1:0] s_set, bit_i, lim_m1;
    logic [SUM_W-1:0] grown;
    logic             elig;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[ra];
    end

    assign s_set  = s_reg[SET_W-1:0];
    assign bit_i  = SET_W'(1) << i_reg[NODE_W-1:0];
    assign lim_m1 = SET_W'(lim_reg - (SET_W+1)'(1));
    assign elig   = ((s_set & bit_i) == '0) && ((info.pred & s_set) == info.pred);
    assign grown  = sat_add(slive_reg, info.weight);

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        lim_next    = lim_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        v_next      = v_reg;
        ns_next     = ns_reg;
        pred_i_next = pred_i_reg;
        np_next     = np_reg;
        nl_next     = nl_reg;
        speak_next  = speak_reg;
        slive_next  = slive_reg;
        res_next    = res_reg;
        we          = 1'b0;
        wa          = s_set;
        wd          = '0;
        ra          = s_set;
        gidx        = i_reg[NODE_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = node_count;
                    lim_next   = (SET_W+1)'(1) << node_count;
                    s_next     = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                if (s_set == lim_m1)
                begin
                    i_next     = '0;
                    state_next = ST_INIT;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            ST_INIT:
            begin
                if (i_reg == (NODE_W+1)'(n_reg))
                begin
                    s_next     = '0;
                    state_next = ST_SREAD;
                end
                else
                begin
                    if (info.pred == '0)
                    begin
                        we = 1'b1;
                        wa = bit_i;
                        wd = '{valid: 1'b1, peak: info.weight, live: info.weight};
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            ST_SREAD:
            begin
                if (s_reg == lim_reg)
                begin
                    state_next = ST_FREAD;
                end
                else
                begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT:
            begin
                if (!rd_q.valid)
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_SREAD;
                end
                else
                begin
                    speak_next = rd_q.peak;
                    slive_next = rd_q.live;
                    i_next     = '0;
                    state_next = ST_ISCAN;
                end
            end
            ST_ISCAN:
            begin
                if (i_reg == (NODE_W+1)'(n_reg))
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_SREAD;
                end
                else if (elig)
                begin
                    ns_next     = s_set | bit_i;
                    ra          = s_set | bit_i;
                    pred_i_next = info.pred;
                    np_next     = (grown > speak_reg) ? grown : speak_reg;
                    nl_next     = grown;
                    state_next  = ST_NWAIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_NWAIT:
            begin
                wa = ns_reg;
                if (rd_q.valid)
                begin
                    // keep the first-visit live value, take the lower or equal peak
                    if (np_reg <= rd_q.peak)
                    begin
                        we = 1'b1;
                        wd = '{valid: 1'b1, peak: np_reg, live: rd_q.live};
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ISCAN;
                end
                else
                begin
                    v_next     = '0;
                    state_next = ST_FREE;
                end
            end
            ST_FREE:
            begin
                gidx = v_reg[NODE_W-1:0];
                wa   = ns_reg;
                if (v_reg == (NODE_W+1)'(n_reg))
                begin
                    we         = 1'b1;
                    wd         = '{valid: 1'b1, peak: np_reg, live: nl_reg};
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ISCAN;
                end
                else
                begin
                    // release a predecessor once all its successors are in the set
                    if (pred_i_reg[v_reg[NODE_W-1:0]] && ((ns_reg & info.succ) == info.succ))
                    begin
                        nl_next = (nl_reg > info.weight) ? nl_reg - info.weight : '0;
                    end
                    v_next = v_reg + 1'b1;
                end
            end
            ST_FREAD:
            begin
                ra         = lim_m1;
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                res_next.no_order = !rd_q.valid;
                res_next.peak     = rd_q.valid ? rd_q.peak : '0;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            s_reg     <= '0;
            lim_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            v_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            lim_reg   <= lim_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            v_reg     <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg     <= ns_next;
        pred_i_reg <= pred_i_next;
        np_reg     <= np_next;
        nl_reg     <= nl_next;
        speak_reg  <= speak_next;
        slive_reg  <= slive_next;
        res_reg    <= res_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == ST_IDLE) |=> (state_reg == ST_CLEAR))
        else $error("solve did not begin with the clearing pass");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((SET_W+1)'(wa) < lim_reg))
        else $error("store write outside the active subset range");

    a_grow_one_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NWAIT || state_reg == ST_FREE) |->
            ((ns_reg & ~s_set) == bit_i && (ns_reg & s_set) == s_set))
        else $error("extended set is not the current set plus one node");

    a_no_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.no_order) |-> (res.peak == '0))
        else $error("unreachable full set reported with a nonzero peak");

endmodule
`default_nettype wire

>>> src/min_peak_memory_dag_order_dp.sv
// A solve with n nodes clears all 2^n subset entries, seeds the nodes with no
// predecessor, then for each subset reads its store word and, if it was reached,
// scans the nodes, reading the store word of each extension and, on a set's
// first visit, passing over the nodes to free predecessors. After the walk the
// result word is held in an output register until taken.
// rst_n clears the edge store, sets node_count to 16 and idles the sequencer.
`default_nettype none
module min_peak_memory_dag_order_dp
    import mpm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    mpm_in_if.sink                in_ch,
    mpm_out_if.source             out_ch,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0]  ncount_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              accept, busy, res_valid, res_ack;
    logic [NODE_W-1:0] gidx;
    node_info_t        info;
    result_t           res;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !busy;
    assign res_ack      = res_valid && (!out_valid_reg || out_ch.ready);

    mpm_graph u_graph (
        .clk         (clk),
        .rst_n       (rst_n),
        .add_en      (accept && in_ch.command == CMD_ADD),
        .clr_en      (accept && in_ch.command == CMD_CLEAR),
        .from_node   (in_ch.from_node),
        .to_node     (in_ch.to_node),
        .edge_weight (in_ch.edge_weight),
        .rd_idx      (gidx),
        .info        (info)
    );

    mpm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && in_ch.command == CMD_SOLVE),
        .node_count (ncount_reg),
        .info       (info),
        .gidx       (gidx),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res),
        .res_ack    (res_ack)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg    <= CNT_W'(MAX_NODES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_data == '0)
                begin
                    ncount_reg <= CNT_W'(1);
                end
                else if (32'(cfg_data) > MAX_NODES)
                begin
                    ncount_reg <= CNT_W'(MAX_NODES);
                end
                else
                begin
                    ncount_reg <= cfg_data;
                end
            end
            if (res_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.peak_memory = out_reg.peak;
    assign out_ch.no_order    = out_reg.no_order;

endmodule
`default_nettype wire

>>> dv/mpm_tb_ifs.sv
`timescale 1ns / 1ps
// Testbench package with the watchdog limit.
package mpm_tb_pkg;
    localparam int unsigned STALL_LIMIT = 400000;
endpackage

>>> dv/min_peak_memory_dag_order_dp_tb.sv
`timescale 1ns / 1ps
// Testbench for the minimal-peak-memory scheduler: directed table, then random graphs.
module min_peak_memory_dag_order_dp_tb;
    import mpm_pkg::*;
    import mpm_tb_pkg::*;

    typedef struct {
        bit          do_cfg;
        bit [4:0]    cfg;
        bit [1:0]    cmd;
        bit [3:0]    src;
        bit [3:0]    dst;
        bit [15:0]   wt;
        bit          typed;
        bit [31:0]   peak;
        bit          no_ord;
    } stim_row_t;

    typedef struct {
        bit [31:0] peak;
        bit        no_ord;
    } sched_result_t;

    localparam bit [1:0] CMD_NOP = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_data;

    mpm_in_if  in_ch ();
    mpm_out_if out_ch ();

    min_peak_memory_dag_order_dp uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // predictor state
    bit [15:0]   g_pred [16];
    bit [15:0]   g_succ [16];
    bit [31:0]   g_wt [16];
    int unsigned n_nodes;
    bit [31:0]   live_s [65536];
    bit [31:0]   peak_s [65536];
    bit          seen_s [65536];

    sched_result_t pending_results [$];
    stim_row_t     dir_rows [$];
    int unsigned   mismatches;
    int unsigned   stall_cycles;
    bit            calm;
    int unsigned   hold_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
        bit [32:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[32] ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < 16; i++)
        begin
            g_pred[i] = '0;
            g_succ[i] = '0;
            g_wt[i]   = '0;
        end
    endfunction

    function automatic void add_row(stim_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic sched_result_t schedule_peak();
        sched_result_t r;
        int unsigned lim;
        bit [15:0] s;
        bit [15:0] ns;
        bit [31:0] grown;
        bit [31:0] np;
        bit [31:0] nl;
        lim = 1 << n_nodes;
        for (int k = 0; k < lim; k++)
        begin
            seen_s[k] = 1'b0;
            live_s[k] = '0;
            peak_s[k] = '0;
        end
        for (int i = 0; i < n_nodes; i++)
        begin
            if (g_pred[i] == 16'd0)
            begin
                live_s[1 << i] = g_wt[i];
                peak_s[1 << i] = g_wt[i];
                seen_s[1 << i] = 1'b1;
            end
        end
        for (int k = 0; k < lim; k++)
        begin
            s = k[15:0];
            if (!seen_s[k])
                continue;
            for (int i = 0; i < n_nodes; i++)
            begin
                if (s[i] || ((g_pred[i] & s) != g_pred[i]))
                    continue;
                ns = s | (16'd1 << i);
                grown = add_sat(live_s[k], g_wt[i]);
                np = (grown > peak_s[k]) ? grown : peak_s[k];
                if (seen_s[ns] && np > peak_s[ns])
                    continue;
                if (!seen_s[ns])
                begin
                    nl = grown;
                    for (int v = 0; v < n_nodes; v++)
                    begin
                        // free a predecessor once all its successors have run
                        if (g_pred[i][v] && ((ns & g_succ[v]) == g_succ[v]))
                            nl = (nl > g_wt[v]) ? nl - g_wt[v] : 32'd0;
                    end
                end
                else
                    nl = live_s[ns];
                peak_s[ns] = np;
                live_s[ns] = nl;
                seen_s[ns] = 1'b1;
            end
        end
        if (seen_s[lim - 1])
        begin
            r.peak = peak_s[lim - 1];
            r.no_ord = 1'b0;
        end
        else
        begin
            r.peak = '0;
            r.no_ord = 1'b1;
        end
        return r;
    endfunction

    function automatic void apply_word(stim_row_t row);
        sched_result_t r;
        case (row.cmd)
            CMD_ADD:
            begin
                g_pred[row.dst] |= 16'd1 << row.src;
                g_succ[row.src] |= 16'd1 << row.dst;
                g_wt[row.src] = add_sat(g_wt[row.src], {16'd0, row.wt});
            end
            CMD_SOLVE:
            begin
                r = schedule_peak();
                if (row.typed)
                begin
                    r.peak = row.peak;
                    r.no_ord = row.no_ord;
                end
                pending_results = {pending_results, r};
            end
            CMD_CLEAR: clear_graph();
            default: ;
        endcase
    endfunction

    // drop the input word, then wait for every expected result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(bit [4:0] value);
        drain();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value < 1)
            n_nodes = 1;
        else if (value > 16)
            n_nodes = 16;
        else
            n_nodes = value;
    endtask

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(stim_row_t row);
        if (row.do_cfg)
            write_count(row.cfg);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= row.cmd;
        in_ch.from_node   <= row.src;
        in_ch.to_node     <= row.dst;
        in_ch.edge_weight <= row.wt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        apply_word(row);
    endtask

    function automatic stim_row_t mk(bit [1:0] cmd, bit [3:0] src, bit [3:0] dst,
                                     bit [15:0] wt);
        stim_row_t r;
        r = '{default: '0};
        r.cmd = cmd;
        r.src = src;
        r.dst = dst;
        r.wt  = wt;
        return r;
    endfunction

    function automatic stim_row_t mk_cfg(bit [4:0] cfg, stim_row_t r);
        r.do_cfg = 1'b1;
        r.cfg = cfg;
        return r;
    endfunction

    function automatic stim_row_t mk_typed(stim_row_t r, bit [31:0] peak, bit no_ord);
        r.typed = 1'b1;
        r.peak = peak;
        r.no_ord = no_ord;
        return r;
    endfunction

    // receiver side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 12);
    end

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: peak=%0h no_order=%0b",
                             out_ch.peak_memory, out_ch.no_order);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.peak_memory !== want.peak || out_ch.no_order !== want.no_ord)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: peak exp=%0h got=%0h, no_order exp=%0b got=%0b",
                                 want.peak, out_ch.peak_memory, want.no_ord,
                                 out_ch.no_order);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[min_peak_memory_dag_order_dp] ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        bit [3:0] a;
        bit [3:0] b;
        int unsigned pick;
        mismatches = 0;
        stall_cycles = 0;
        calm = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_NOP;
        in_ch.from_node = '0;
        in_ch.to_node = '0;
        in_ch.edge_weight = '0;
        n_nodes = 16;
        clear_graph();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero count clamps to one node; empty graph peaks at zero
        add_row(mk_cfg(5'd0, mk_typed(mk(CMD_SOLVE, 0, 0, 0), 32'd0, 1'b0)));
        // self edge leaves no full order
        add_row(mk(CMD_ADD, 0, 0, 16'hFFFF));
        add_row(mk_typed(mk(CMD_SOLVE, 0, 0, 0), 32'd0, 1'b1));
        add_row(mk(CMD_CLEAR, 0, 0, 0));
        // duplicate edges add weight
        add_row(mk_cfg(5'd2, mk(CMD_ADD, 0, 1, 16'hFFFF)));
        add_row(mk(CMD_ADD, 0, 1, 16'hFFFF));
        add_row(mk_typed(mk(CMD_SOLVE, 0, 0, 0), 32'h0001_FFFE, 1'b0));
        // cycle
        add_row(mk(CMD_ADD, 1, 0, 16'd1));
        add_row(mk_typed(mk(CMD_SOLVE, 0, 0, 0), 32'd0, 1'b1));
        add_row(mk(CMD_CLEAR, 0, 0, 0));
        add_row(mk(CMD_NOP, 15, 15, 16'hFFFF));
        // successor above the node count is never freed
        add_row(mk_cfg(5'd4, mk(CMD_ADD, 0, 15, 16'd5)));
        add_row(mk(CMD_ADD, 0, 2, 16'd7));
        add_row(mk(CMD_ADD, 1, 3, 16'h8000));
        add_row(mk(CMD_ADD, 2, 3, 16'd3));
        add_row(mk(CMD_SOLVE, 0, 0, 0));
        // predecessor above the node count blocks its node
        add_row(mk(CMD_ADD, 14, 1, 16'd1));
        add_row(mk_typed(mk(CMD_SOLVE, 0, 0, 0), 32'd0, 1'b1));
        // oversized count clamps to sixteen; load only
        add_row(mk_cfg(5'd31, mk(CMD_CLEAR, 0, 0, 0)));
        add_row(mk(CMD_ADD, 15, 0, 16'd0));
        add_row(mk_cfg(5'd16, mk(CMD_CLEAR, 0, 0, 0)));
        add_row(mk_cfg(5'd10, mk(CMD_ADD, 3, 9, 16'd100)));
        add_row(mk(CMD_ADD, 9, 5, 16'd40));
        add_row(mk(CMD_SOLVE, 0, 0, 0));
        foreach (dir_rows[i])
            send_word(dir_rows[i]);

        // fill up the block while the receiver holds off
        write_count(5'd3);
        hold_cycles = 2000;
        send_word(mk(CMD_SOLVE, 0, 0, 0));
        send_word(mk(CMD_ADD, 0, 1, 16'd9));
        send_word(mk(CMD_SOLVE, 0, 0, 0));
        send_word(mk(CMD_ADD, 1, 2, 16'd4));
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_count(5'($urandom_range(7, 1)));
            calm = (phase == 2);
            send_word(mk(CMD_CLEAR, 0, 0, 0));
            for (int k = 0; k < 15; k++)
            begin
                pick = $urandom_range(99);
                a = 4'($urandom_range(15));
                b = 4'($urandom_range(15));
                if (pick < 70 && $urandom_range(9) < 8)
                begin
                    // keep most edges forward within the used nodes
                    a = 4'($urandom_range(n_nodes - 1));
                    b = 4'($urandom_range(n_nodes - 1));
                    if (a > b)
                        {a, b} = {b, a};
                    if (a == b && $urandom_range(3) != 0)
                        continue;
                end
                if (pick < 70)
                    row = mk(CMD_ADD, a, b, 16'($urandom_range(16'hFFFF)));
                else if (pick < 90)
                    row = mk(CMD_SOLVE, a, b, 16'($urandom_range(16'hFFFF)));
                else if (pick < 95)
                    row = mk(CMD_CLEAR, a, b, 16'($urandom_range(16'hFFFF)));
                else
                    row = mk(CMD_NOP, a, b, 16'($urandom_range(16'hFFFF)));
                send_word(row);
            end
            send_word(mk(CMD_SOLVE, 0, 0, 0));
        end
        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[min_peak_memory_dag_order_dp] OK");
        else
            $display("[min_peak_memory_dag_order_dp] ERROR");
        $finish;
    end
endmodule
